/* hdl/relay_channel_retrigger_timer_defines.svh */
// Assertion macros for the relay channel retrigger timer
`ifndef RELAY_CHANNEL_RETRIGGER_TIMER_DEFINES_SVH
`define RELAY_CHANNEL_RETRIGGER_TIMER_DEFINES_SVH
`ifndef SYNTHESIS
`define RCRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RCRT_ASSERT(lbl, prop, msg)
`define RCRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/rcrt_pkg.sv */
// Shared widths, codes and defaults for the relay channel retrigger timer
`timescale 1ns / 1ps
package rcrt_pkg;

  localparam int OP_W    = 2;
  localparam int CH_W    = 4;
  localparam int VAL_W   = 10;
  localparam int KIND_W  = 2;
  localparam int ERR_W   = 2;
  localparam int LINES_W = 16;
  localparam int CNT_W   = 5;

  // at most this many channels are addressable by the 4-bit channel field
  localparam int BANK_MAX = 16;

  localparam int CHANNELS_DEF    = 16;
  localparam int MAX_SECONDS_DEF = 999;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_SET  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_CHANNEL = 2'd2;

endpackage

/* hdl/rcrt_ifs.sv */
// Valid/ready channel interfaces: command input, result output, configuration write
`timescale 1ns / 1ps

interface rcrt_in_if import rcrt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [CH_W-1:0]  channel;
  logic [VAL_W-1:0] value;

  modport source (output valid, op, channel, value, input ready);
  modport sink (input valid, op, channel, value, output ready);
endinterface

interface rcrt_out_if import rcrt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ERR_W-1:0]   error_code;
  logic [CH_W-1:0]    channel_res;
  logic [VAL_W-1:0]   echo_value;
  logic [LINES_W-1:0] line_states;
  logic               last;

  modport source (output valid, kind, error_code, channel_res, echo_value, line_states, last,
                  input ready);
  modport sink (input valid, kind, error_code, channel_res, echo_value, line_states, last,
                output ready);
endinterface

interface rcrt_cfg_if import rcrt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] channel_count;

  modport source (output valid, channel_count, input ready);
  modport sink (input valid, channel_count, output ready);
endinterface

/* hdl/relay_channel_retrigger_timer.sv */
// Relay channel retrigger timer: bank of relay lines with retriggerable second countdowns
// One command is taken at a time. A set or read, once in the command state, puts its single
// result into the output register and frees the input in that same cycle; an error likewise. Both
// wait while the output register still holds an untaken result. A tick walks the channels in
// use through the countdown memory, one channel per cycle over its single read port while
// the result side does not hold back an expiry notice, then passes a flush state that hands
// on the last held notice before the input is free again. Results sit in an output register,
// so the next command is taken while the last result still waits. Line levels and running
// flags live in flip-flops; the remaining seconds live in a synchronous memory.
`timescale 1ns / 1ps
`include "relay_channel_retrigger_timer_defines.svh"

module relay_channel_retrigger_timer import rcrt_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int MAX_SECONDS = MAX_SECONDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rcrt_in_if.sink    in_if,
  rcrt_out_if.source out_if,
  rcrt_cfg_if.sink   cfg_if
);

  localparam int NCH    = (CHANNELS < BANK_MAX) ? CHANNELS : BANK_MAX;
  localparam int IDX_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SCAN_W = $clog2(NCH + 1);
  localparam logic [CNT_W-1:0] NCH_L  = CNT_W'(NCH);
  localparam logic [16:0]      MAXS_L = 17'(MAX_SECONDS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMD   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_act;

  logic [OP_W-1:0]  op_r;
  logic [CH_W-1:0]  ch_r;
  logic [VAL_W-1:0] val_r;

  logic [NCH-1:0] run_r, run_nxt;
  logic [NCH-1:0] line_r, line_nxt;

  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_ch_r, rd_ch_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]  pend_ch_r, pend_ch_nxt;

  // countdown memory
  logic [VAL_W-1:0] sec_mem [NCH];
  logic [VAL_W-1:0] sec_q_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata;

  logic               out_vld_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [ERR_W-1:0]   out_err_r;
  logic [CH_W-1:0]    out_ch_r;
  logic [VAL_W-1:0]   out_echo_r;
  logic [LINES_W-1:0] out_lines_r;
  logic               out_last_r;

  logic               push;
  logic [KIND_W-1:0]  push_kind;
  logic [ERR_W-1:0]   push_err;
  logic [CH_W-1:0]    push_ch;
  logic [VAL_W-1:0]   push_echo;
  logic [LINES_W-1:0] push_lines;
  logic               push_last;

  logic               can_push;
  logic [LINES_W-1:0] act_mask;
  logic [LINES_W-1:0] lines_now;
  logic               val_bad;
  logic               ch_bad;
  logic               expire;
  logic               stall;

  assign n_act    = (count_r > NCH_L) ? NCH_L : count_r;
  assign can_push = !out_vld_r || out_if.ready;
  assign val_bad  = {7'd0, val_r} > MAXS_L;
  assign ch_bad   = {1'b0, ch_r} >= n_act;
  assign expire   = rd_vld_r && run_r[rd_ch_r] && (sec_q_r <= VAL_W'(1));
  // a second expiry must move the held notice out before it can be kept
  assign stall    = expire && pend_vld_r && !can_push;

  always_comb begin
    for (int i = 0; i < LINES_W; i++) begin
      act_mask[i] = CNT_W'(i) < n_act;
    end
    lines_now = LINES_W'(line_r) & act_mask;
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    run_nxt      = run_r;
    line_nxt     = line_r;
    scan_nxt     = scan_r;
    rd_vld_nxt   = rd_vld_r;
    rd_ch_nxt    = rd_ch_r;
    pend_vld_nxt = pend_vld_r;
    pend_ch_nxt  = pend_ch_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    push         = 1'b0;
    push_kind    = KIND_ACK;
    push_err     = ERR_NONE;
    push_ch      = '0;
    push_echo    = '0;
    push_lines   = '0;
    push_last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          state_nxt = S_CMD;
        end
      end

      S_CMD: begin
        case (op_r)
          OP_SET: begin
            if (can_push) begin
              push      = 1'b1;
              push_ch   = ch_r;
              state_nxt = S_IDLE;
              if (val_bad) begin
                push_kind = KIND_ERROR;
                push_err  = ERR_RANGE;
              end else if (ch_bad) begin
                push_kind = KIND_ERROR;
                push_err  = ERR_CHANNEL;
              end else begin
                push_echo = val_r;
                if (val_r >= VAL_W'(2)) begin
                  run_nxt[ch_r[IDX_W-1:0]]  = 1'b1;
                  line_nxt[ch_r[IDX_W-1:0]] = 1'b1;
                  mem_we    = 1'b1;
                  mem_waddr = ch_r[IDX_W-1:0];
                  mem_wdata = val_r;
                end else begin
                  run_nxt[ch_r[IDX_W-1:0]]  = 1'b0;
                  line_nxt[ch_r[IDX_W-1:0]] = val_r[0];
                end
              end
            end
          end
          OP_READ: begin
            if (can_push) begin
              push       = 1'b1;
              push_kind  = KIND_READ;
              push_lines = lines_now;
              state_nxt  = S_IDLE;
            end
          end
          OP_TICK: begin
            scan_nxt   = '0;
            rd_vld_nxt = 1'b0;
            state_nxt  = S_SCAN;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        if (!stall) begin
          // evaluate the channel whose seconds came back from the memory
          if (rd_vld_r && run_r[rd_ch_r]) begin
            if (expire) begin
              run_nxt[rd_ch_r]  = 1'b0;
              line_nxt[rd_ch_r] = 1'b0;
              pend_vld_nxt      = 1'b1;
              pend_ch_nxt       = rd_ch_r;
              if (pend_vld_r) begin
                push      = 1'b1;
                push_kind = KIND_EXPIRY;
                push_ch   = CH_W'(pend_ch_r);
                push_last = 1'b0;
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = rd_ch_r;
              mem_wdata = sec_q_r - VAL_W'(1);
            end
          end
          // fetch the next channel
          if (CNT_W'(scan_r) < n_act) begin
            mem_re     = 1'b1;
            mem_raddr  = scan_r[IDX_W-1:0];
            scan_nxt   = scan_r + SCAN_W'(1);
            rd_vld_nxt = 1'b1;
            rd_ch_nxt  = scan_r[IDX_W-1:0];
          end else begin
            rd_vld_nxt = 1'b0;
            if (!rd_vld_r) begin
              state_nxt = S_FLUSH;
            end
          end
        end
      end

      S_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (can_push) begin
          push         = 1'b1;
          push_kind    = KIND_EXPIRY;
          push_ch      = CH_W'(pend_ch_r);
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sec_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      sec_q_r <= sec_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= COUNT_RESET;
      run_r      <= '0;
      line_r     <= '0;
      scan_r     <= '0;
      rd_vld_r   <= 1'b0;
      rd_ch_r    <= '0;
      pend_vld_r <= 1'b0;
      pend_ch_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      run_r      <= run_nxt;
      line_r     <= line_nxt;
      scan_r     <= scan_nxt;
      rd_vld_r   <= rd_vld_nxt;
      rd_ch_r    <= rd_ch_nxt;
      pend_vld_r <= pend_vld_nxt;
      pend_ch_r  <= pend_ch_nxt;
      if (cfg_if.valid) begin
        count_r <= cfg_if.channel_count;
      end
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      op_r  <= in_if.op;
      ch_r  <= in_if.channel;
      val_r <= in_if.value;
    end
    if (push) begin
      out_kind_r  <= push_kind;
      out_err_r   <= push_err;
      out_ch_r    <= push_ch;
      out_echo_r  <= push_echo;
      out_lines_r <= push_lines;
      out_last_r  <= push_last;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.error_code  = out_err_r;
  assign out_if.channel_res = out_ch_r;
  assign out_if.echo_value  = out_echo_r;
  assign out_if.line_states = out_lines_r;
  assign out_if.last        = out_last_r;

  // a running countdown always holds its line on
  `RCRT_ASSERT(a_run_implies_on, ((run_r & ~line_r) == '0), "timer running on an off line")
  // an expiry notice waiting on the output refers to a line already off
  `RCRT_ASSERT(a_expiry_line_off, ((out_vld_r && out_kind_r == KIND_EXPIRY) |-> !line_r[out_ch_r[IDX_W-1:0]]), "expired line still on")
  // no notice may be left behind when a command completes
  `RCRT_ASSERT(a_idle_no_pend, ((state_r == S_IDLE) |-> !pend_vld_r), "expiry notice lost")
  `RCRT_ASSERT(a_read_in_scan, (rd_vld_r |-> (state_r == S_SCAN)), "memory read outside scan")
  `RCRT_ASSERT_NEXT(a_tick_start, (state_r == S_CMD && op_r == OP_TICK), (state_r == S_SCAN && !rd_vld_r && scan_r == '0), "tick scan did not start clean")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the relay channel retrigger timer: driver, monitor, predictor
`timescale 1ns / 1ps

module tb_top;
  import rcrt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;
  } relay_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ERR_W-1:0]   error_code;
    logic [CH_W-1:0]    channel_res;
    logic [VAL_W-1:0]   echo_value;
    logic [LINES_W-1:0] line_states;
    logic               last;
  } relay_result_t;

  logic clk;
  logic rst_n;

  rcrt_in_if  in_if ();
  rcrt_out_if out_if ();
  rcrt_cfg_if cfg_if ();

  relay_channel_retrigger_timer i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  relay_cmd_t    cmd_fifo[$];
  relay_result_t pending_results[$];
  int            fail_count;
  int            send_idle_pct;
  int            out_stall_pct;

  // shadow of the timer bank
  logic             line_on   [BANK_MAX];
  logic             timer_on  [BANK_MAX];
  logic [VAL_W-1:0] secs_left [BANK_MAX];
  logic [CNT_W-1:0] chan_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("relay_channel_retrigger_timer regression: fail");
    $finish;
  end

  function automatic int active_channels();
    int n;
    n = chan_count;
    if (n > CHANNELS_DEF) n = CHANNELS_DEF;
    if (n > BANK_MAX) n = BANK_MAX;
    return n;
  endfunction

  task report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task predict_command(input relay_cmd_t c);
    int            n;
    int            i;
    int            hits;
    relay_result_t r;
    n = active_channels();
    hits = 0;
    r = '0;
    r.last = 1'b1;
    case (c.op)
      OP_SET: begin
        r.channel_res = c.channel;
        if (c.value > MAX_SECONDS_DEF) begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_RANGE;
        end else if (c.channel >= n) begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_CHANNEL;
        end else begin
          if (c.value >= 2) begin
            line_on[c.channel] = 1'b1;
            timer_on[c.channel] = 1'b1;
            secs_left[c.channel] = c.value;
          end else begin
            timer_on[c.channel] = 1'b0;
            line_on[c.channel] = c.value[0];
          end
          r.kind = KIND_ACK;
          r.error_code = ERR_NONE;
          r.echo_value = c.value;
        end
        pending_results.push_back(r);
      end
      OP_READ: begin
        r.kind = KIND_READ;
        for (i = 0; i < n; i++)
          if (line_on[i]) r.line_states[i] = 1'b1;
        pending_results.push_back(r);
      end
      OP_TICK: begin
        for (i = 0; i < n; i++) begin
          if (timer_on[i]) begin
            if (secs_left[i] <= 1) begin
              secs_left[i] = '0;
              timer_on[i] = 1'b0;
              line_on[i] = 1'b0;
              r = '0;
              r.kind = KIND_EXPIRY;
              r.channel_res = i[CH_W-1:0];
              pending_results.push_back(r);
              hits++;
            end else begin
              secs_left[i] = secs_left[i] - 1'b1;
            end
          end
        end
        if (hits > 0) pending_results[pending_results.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // command driver
  always @(posedge clk) begin : cmd_driver
    relay_cmd_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        predict_command('{in_if.op, in_if.channel, in_if.value});
      if (!in_if.valid || in_if.ready) begin
        if (cmd_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmd_fifo.pop_front();
          in_if.valid   <= 1'b1;
          in_if.op      <= nxt.op;
          in_if.channel <= nxt.channel;
          in_if.value   <= nxt.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    relay_result_t got;
    relay_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_stall_pct);
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.kind, out_if.error_code, out_if.channel_res, out_if.echo_value,
                out_if.line_states, out_if.last};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.error_code !== want.error_code ||
              got.channel_res !== want.channel_res || got.echo_value !== want.echo_value ||
              got.line_states !== want.line_states || got.last !== want.last)
            report_mismatch($sformatf("got %p, want %p", got, want));
        end
      end
    end
  end

  task queue_cmd(input logic [OP_W-1:0] op, input int ch, input int val);
    cmd_fifo.push_back('{op, ch[CH_W-1:0], val[VAL_W-1:0]});
  endtask

  // mostly well-formed traffic with short timers so expiries are frequent
  task queue_random_cmds(input int count);
    int left;
    int sel;
    int ch;
    int val;
    int n;
    left = count;
    n = active_channels();
    while (left > 0) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        queue_cmd(OP_UNUSED, $urandom_range(15), $urandom_range(1023));
      end else begin
        if (sel < 45) begin
          if (n > 0 && $urandom_range(9) < 8) ch = $urandom_range(n - 1);
          else ch = $urandom_range(15);
          sel = $urandom_range(99);
          if (sel < 65) val = $urandom_range(8, 2);
          else if (sel < 78) val = $urandom_range(1);
          else if (sel < 90) val = $urandom_range(MAX_SECONDS_DEF, 9);
          else val = $urandom_range(1023, MAX_SECONDS_DEF + 1);
          queue_cmd(OP_SET, ch, val);
        end else if (sel < 60) begin
          queue_cmd(OP_READ, $urandom_range(15), $urandom_range(1023));
        end else begin
          queue_cmd(OP_TICK, $urandom_range(15), $urandom_range(1023));
        end
        left--;
      end
    end
  endtask

  // sampled on the falling edge so all transfers of the rising edge have settled
  task wait_idle();
    do @(negedge clk);
    while (cmd_fifo.size() != 0 || in_if.valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_channel_count(input int cnt);
    @(posedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.channel_count <= cnt[CNT_W-1:0];
    do @(posedge clk);
    while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    chan_count = cnt[CNT_W-1:0];
  endtask

  task run_phase(input int cnt, input int snd_pct, input int rcv_pct, input int count);
    write_channel_count(cnt);
    send_idle_pct = snd_pct;
    out_stall_pct = rcv_pct;
    queue_random_cmds(count);
    wait_idle();
  endtask

  initial begin
    int i;
    fail_count    = 0;
    send_idle_pct = 0;
    out_stall_pct = 0;
    chan_count    = COUNT_RESET;
    for (i = 0; i < BANK_MAX; i++) begin
      line_on[i]   = 1'b0;
      timer_on[i]  = 1'b0;
      secs_left[i] = '0;
    end
    in_if.valid          = 1'b0;
    in_if.op             = OP_SET;
    in_if.channel        = '0;
    in_if.value          = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.channel_count = COUNT_RESET;
    rst_n                = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: static levels, value extremes, range errors, retrigger, expiries
    queue_cmd(OP_SET, 0, 0);
    queue_cmd(OP_SET, 15, 1);
    queue_cmd(OP_SET, 3, 2);
    queue_cmd(OP_SET, 7, MAX_SECONDS_DEF);
    queue_cmd(OP_SET, 2, MAX_SECONDS_DEF + 1);
    queue_cmd(OP_SET, 9, 1023);
    queue_cmd(OP_READ, 0, 0);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_SET, 4, 2);
    queue_cmd(OP_TICK, 15, 1023);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_UNUSED, 5, 7);
    queue_cmd(OP_SET, 3, 5);
    queue_cmd(OP_SET, 3, 3);
    queue_cmd(OP_SET, 5, 2);
    queue_cmd(OP_SET, 14, 2);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_READ, 0, 0);
    queue_cmd(OP_SET, 7, 0);
    queue_cmd(OP_SET, 15, 0);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_READ, 15, 1023);
    wait_idle();

    run_phase(1, 57, 0, 30);
    run_phase(0, 0, 57, 20);
    run_phase(31, 31, 31, 40);
    // lowered count: timers above channel 4 stay frozen
    run_phase(5, 0, 0, 30);
    run_phase(16, 57, 0, 30);
    run_phase(17, 0, 57, 20);
    run_phase(9, 31, 31, 20);

    if (fail_count == 0) begin
      $display("relay_channel_retrigger_timer regression: pass");
    end else begin
      $display("relay_channel_retrigger_timer regression: fail");
    end
    $finish;
  end

endmodule
